// ===== rtl/tscb_pkg.sv =====
package tscb_pkg;

   localparam int ROWS      = 32;
   localparam int COLS      = 64;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W     = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int CUR_ROW_W = 5;
   localparam int CUR_COL_W = 6;
   localparam int REQ_W     = 64;
   localparam int RSP_W     = 24;
   localparam int SPAN_W    = 10;

   localparam logic [8:0] ROWS_LIM = 9'(ROWS);
   localparam logic [8:0] COLS_LIM = 9'(COLS);

   localparam logic [2:0] MODE_SET_CURSOR = 3'd0;
   localparam logic [2:0] MODE_SET_STYLE  = 3'd1;
   localparam logic [2:0] MODE_PUT_CHAR   = 3'd2;
   localparam logic [2:0] MODE_ERASE      = 3'd3;
   localparam logic [2:0] MODE_SCROLL     = 3'd4;
   localparam logic [2:0] MODE_READ       = 3'd5;

   typedef struct packed {
      logic       reverse;
      logic [7:0] code;
   } cell_type;

   localparam cell_type BLANK_CELL = '{reverse: 1'b0, code: 8'h20};

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      cell_type          wdata;
   } ram_req_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [7:0]       row;
      logic [7:0]       col;
      logic [7:0]       row_end;
      logic [7:0]       col_end;
      logic signed [8:0] scroll_amount;
      logic [7:0]       char_code;
      logic [7:0]       style_bits;
   } cmd_type;

   typedef struct packed {
      logic [CUR_COL_W-1:0] cursor_col;
      logic [CUR_ROW_W-1:0] cursor_row;
      logic                 cell_reverse;
      logic [7:0]           cell_char;
   } res_type;

   function automatic logic [7:0] clamp_pos(input logic [7:0] v, input logic [8:0] lim);
      logic [8:0] p;
      p = (v == 8'd0) ? 9'd0 : ({1'b0, v} - 9'd1);
      if (p > lim - 9'd1) p = lim - 9'd1;
      return p[7:0];
   endfunction

   function automatic logic [7:0] span_lo(input logic [7:0] a);
      return (a == 8'd0) ? 8'd0 : (a - 8'd1);
   endfunction

   function automatic logic [7:0] span_hi(input logic [7:0] b, input logic [8:0] lim);
      logic [8:0] e;
      e = {1'b0, b} - 9'd1;
      if (e > lim - 9'd1) e = lim - 9'd1;
      return e[7:0];
   endfunction

   function automatic logic span_empty(input logic [7:0] a, input logic [7:0] b,
                                       input logic [8:0] lim);
      return (b == 8'd0) || (span_lo(a) > span_hi(b, lim));
   endfunction

endpackage

// ===== rtl/text_screen_cell_buffer_top.sv =====
// Cursor, style, read and out-of-screen commands go from accept straight to the result.
// Put char writes one cell; a row wrap then blanks each cell of the new row.
// Erase blanks each cell of the clipped area; scroll copies each cell by a read
// and a write, blanks the rest, all through the single port of the cell memory.
// One request is in work at a time; the result waits in an output register.
// Reset is synchronous; afterward all 2048 cells of the cell memory are zeroed.
module text_screen_cell_buffer_top
   import tscb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // row, col, row_end, col_end, scroll_amount, char_code, style_bits, zero fill
   input  logic [REQ_W-1:0] req_tdata,
   // mode
   input  logic [2:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // cell_char, cell_reverse, cursor_row, cursor_col, zero fill
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type     cmd;
   res_type     res;
   logic        res_valid, res_ready;
   ram_req_type ram_req;
   cell_type    ram_rdata;
   logic        rsp_valid_ff;
   res_type     rsp_data_ff;

   always_comb begin
      cmd.mode          = req_tuser;
      cmd.row           = req_tdata[7:0];
      cmd.col           = req_tdata[15:8];
      cmd.row_end       = req_tdata[23:16];
      cmd.col_end       = req_tdata[31:24];
      cmd.scroll_amount = req_tdata[40:32];
      cmd.char_code     = req_tdata[48:41];
      cmd.style_bits    = req_tdata[56:49];
   end

   tscb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd       (cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   tscb_cell_ram u_cell_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) rsp_data_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - $bits(res_type))'(0), rsp_data_ff};

endmodule

// ===== rtl/tscb_cell_ram.sv =====
module tscb_cell_ram
   import tscb_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output cell_type    ram_rdata
);

   cell_type mem [2**ADDR_W];
   cell_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en) begin
         if (ram_req.we) begin
            mem[ram_req.addr] <= ram_req.wdata;
         end else begin
            rdata_ff <= mem[ram_req.addr];
         end
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

// ===== rtl/tscb_ctrl.sv =====
module tscb_ctrl
   import tscb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        res_valid,
   input  logic        res_ready,
   output res_type     res,
   output ram_req_type ram_req,
   input  cell_type    ram_rdata
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RD    = 5'b00100,
      ST_WR    = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic              rev_ff, rev_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [ROW_W-1:0]  top_ff, top_in, bot_ff, bot_in, y_ff, y_in;
   logic [COL_W-1:0]  left_ff, left_in, right_ff, right_in, x_ff, x_in;
   logic              down_ff, down_in, scroll_ff, scroll_in;
   logic [8:0]        units_ff, units_in;

   logic [ROW_W-1:0]  row_t, row_b, next_row, src_row, y_step;
   logic [COL_W-1:0]  col_l, col_r;
   logic              area_empty, last_cell, copy_row;
   logic [SPAN_W-1:0] src_up, dn_lim;
   logic [8:0]        amt_abs;

   assign row_t      = ROW_W'(span_lo(cmd.row));
   assign row_b      = ROW_W'(span_hi(cmd.row_end, ROWS_LIM));
   assign col_l      = COL_W'(span_lo(cmd.col));
   assign col_r      = COL_W'(span_hi(cmd.col_end, COLS_LIM));
   assign area_empty = span_empty(cmd.row, cmd.row_end, ROWS_LIM)
                    || span_empty(cmd.col, cmd.col_end, COLS_LIM);
   assign amt_abs    = cmd.scroll_amount[8] ? (~cmd.scroll_amount + 9'd1)
                                            : cmd.scroll_amount;
   assign next_row   = (cur_row_ff == ROW_W'(ROWS - 1)) ? '0 : (cur_row_ff + ROW_W'(1));

   assign src_up   = SPAN_W'(y_ff) + SPAN_W'(units_ff);
   assign dn_lim   = SPAN_W'(top_ff) + SPAN_W'(units_ff);
   assign copy_row = scroll_ff && (down_ff ? (SPAN_W'(y_ff) >= dn_lim)
                                           : (src_up <= SPAN_W'(bot_ff)));
   assign src_row  = down_ff ? (y_ff - ROW_W'(units_ff)) : src_up[ROW_W-1:0];
   assign y_step   = down_ff ? (y_ff - ROW_W'(1)) : (y_ff + ROW_W'(1));
   assign last_cell = (x_ff == right_ff) && (y_ff == (down_ff ? top_ff : bot_ff));

   assign cmd_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res.cell_char    = rd_ok_ff ? ram_rdata.code : 8'd0;
      res.cell_reverse = rd_ok_ff ? ram_rdata.reverse : 1'b0;
      res.cursor_row   = CUR_ROW_W'(cur_row_ff);
      res.cursor_col   = CUR_COL_W'(cur_col_ff);
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      rev_in      = rev_ff;
      rd_ok_in    = rd_ok_ff;
      top_in      = top_ff;
      bot_in      = bot_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      y_in        = y_ff;
      x_in        = x_ff;
      down_in     = down_ff;
      scroll_in   = scroll_ff;
      units_in    = units_ff;
      ram_req     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = clr_addr_ff;
            ram_req.wdata = '0;
            clr_addr_in   = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_DONE;
               rd_ok_in = 1'b0;
               unique case (cmd.mode)
                  MODE_SET_CURSOR: begin
                     cur_row_in = ROW_W'(clamp_pos(cmd.row, ROWS_LIM));
                     cur_col_in = COL_W'(clamp_pos(cmd.col, COLS_LIM));
                  end
                  MODE_SET_STYLE: begin
                     rev_in = cmd.style_bits[0];
                  end
                  MODE_PUT_CHAR: begin
                     ram_req.en    = 1'b1;
                     ram_req.we    = 1'b1;
                     ram_req.addr  = {cur_row_ff, cur_col_ff};
                     ram_req.wdata = '{reverse: rev_ff, code: cmd.char_code};
                     if (cur_col_ff == COL_W'(COLS - 1)) begin
                        cur_col_in = '0;
                        cur_row_in = next_row;
                        top_in     = next_row;
                        bot_in     = next_row;
                        y_in       = next_row;
                        left_in    = '0;
                        x_in       = '0;
                        right_in   = COL_W'(COLS - 1);
                        down_in    = 1'b0;
                        scroll_in  = 1'b0;
                        state_in   = ST_RD;
                     end else begin
                        cur_col_in = cur_col_ff + COL_W'(1);
                     end
                  end
                  MODE_ERASE, MODE_SCROLL: begin
                     if (!area_empty &&
                         !(cmd.mode == MODE_SCROLL && cmd.scroll_amount == 9'sd0)) begin
                        top_in    = row_t;
                        bot_in    = row_b;
                        left_in   = col_l;
                        right_in  = col_r;
                        x_in      = col_l;
                        scroll_in = (cmd.mode == MODE_SCROLL);
                        down_in   = (cmd.mode == MODE_SCROLL) && cmd.scroll_amount[8];
                        y_in      = ((cmd.mode == MODE_SCROLL) && cmd.scroll_amount[8])
                                    ? row_b : row_t;
                        units_in  = amt_abs;
                        state_in  = ST_RD;
                     end
                  end
                  MODE_READ: begin
                     if (cmd.row != 8'd0 && {1'b0, cmd.row} <= ROWS_LIM &&
                         cmd.col != 8'd0 && {1'b0, cmd.col} <= COLS_LIM) begin
                        ram_req.en   = 1'b1;
                        ram_req.addr = {ROW_W'(cmd.row - 8'd1), COL_W'(cmd.col - 8'd1)};
                        rd_ok_in     = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD: begin
            ram_req.en = 1'b1;
            if (copy_row) begin
               ram_req.addr = {src_row, x_ff};
               state_in     = ST_WR;
            end else begin
               ram_req.we    = 1'b1;
               ram_req.addr  = {y_ff, x_ff};
               ram_req.wdata = BLANK_CELL;
               if (last_cell) begin
                  state_in = ST_DONE;
               end else if (x_ff == right_ff) begin
                  x_in = left_ff;
                  y_in = y_step;
               end else begin
                  x_in = x_ff + COL_W'(1);
               end
            end
         end
         ST_WR: begin
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = {y_ff, x_ff};
            ram_req.wdata = ram_rdata;
            state_in      = ST_RD;
            if (last_cell) begin
               state_in = ST_DONE;
            end else if (x_ff == right_ff) begin
               x_in = left_ff;
               y_in = y_step;
            end else begin
               x_in = x_ff + COL_W'(1);
            end
         end
         ST_DONE: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         rev_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         rev_ff      <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff  <= rd_ok_in;
      top_ff    <= top_in;
      bot_ff    <= bot_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      y_ff      <= y_in;
      x_ff      <= x_in;
      down_ff   <= down_in;
      scroll_ff <= scroll_in;
      units_ff  <= units_in;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import tscb_pkg::*;

   localparam int RAND_REQUESTS = 650;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT       = 450;
   localparam int MAX_LINES     = 100;

   typedef struct {
      cmd_type cmd;
      bit      typed;
      res_type res;
   } dir_row_t;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [2:0]       req_tuser  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   cell_type screen_img [ROWS][COLS];
   int       cur_line;
   int       cur_colm;
   logic     rev_on;
   res_type  rsp_expect_q [$];
   dir_row_t dir_rows [$];

   int mismatches;
   int results_seen;
   int requests_sent;
   int wrap_count;
   int hold_left;
   bit quiet;
   bit hold_request;

   text_screen_cell_buffer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_LINES) $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   function automatic int sat_index(input logic [7:0] v, input int lim);
      int p;
      p = int'(v) - 1;
      if (p < 0) p = 0;
      if (p > lim - 1) p = lim - 1;
      return p;
   endfunction

   function automatic bit clip_range(input logic [7:0] a, input logic [7:0] b, input int lim,
                                     output int lo, output int hi);
      lo = int'(a) - 1;
      hi = int'(b) - 1;
      if (lo < 0) lo = 0;
      if (hi > lim - 1) hi = lim - 1;
      return lo <= hi;
   endfunction

   function automatic void blank_area(input int t, input int b, input int l, input int r);
      for (int y = t; y <= b; y++)
         for (int x = l; x <= r; x++)
            screen_img[y][x] = BLANK_CELL;
   endfunction

   function automatic void shift_area(input int t, input int b, input int l, input int r,
                                      input int amt);
      int h;
      int u;
      h = b - t + 1;
      u = (amt > 0) ? amt : -amt;
      if (amt == 0) return;
      if (u >= h) begin
         blank_area(t, b, l, r);
      end else if (amt > 0) begin
         for (int y = t; y <= b - u; y++)
            for (int x = l; x <= r; x++)
               screen_img[y][x] = screen_img[y + u][x];
         blank_area(b - u + 1, b, l, r);
      end else begin
         for (int y = b; y >= t + u; y--)
            for (int x = l; x <= r; x++)
               screen_img[y][x] = screen_img[y - u][x];
         blank_area(t, t + u - 1, l, r);
      end
   endfunction

   function automatic res_type predict_screen(input cmd_type c);
      res_type r;
      int      t, b, l, rt;
      r = '0;
      case (c.mode)
         MODE_SET_CURSOR: begin
            cur_line = sat_index(c.row, ROWS);
            cur_colm = sat_index(c.col, COLS);
         end
         MODE_SET_STYLE: rev_on = c.style_bits[0];
         MODE_PUT_CHAR: begin
            screen_img[cur_line][cur_colm] = '{reverse: rev_on, code: c.char_code};
            cur_colm++;
            if (cur_colm >= COLS) begin
               cur_colm = 0;
               cur_line = (cur_line + 1) % ROWS;
               blank_area(cur_line, cur_line, 0, COLS - 1);
               wrap_count++;
            end
         end
         MODE_ERASE: begin
            if (clip_range(c.row, c.row_end, ROWS, t, b) &&
                clip_range(c.col, c.col_end, COLS, l, rt))
               blank_area(t, b, l, rt);
         end
         MODE_SCROLL: begin
            if (clip_range(c.row, c.row_end, ROWS, t, b) &&
                clip_range(c.col, c.col_end, COLS, l, rt))
               shift_area(t, b, l, rt, int'($signed(c.scroll_amount)));
         end
         MODE_READ: begin
            if (c.row >= 1 && c.row <= ROWS && c.col >= 1 && c.col <= COLS) begin
               r.cell_char    = screen_img[c.row - 1][c.col - 1].code;
               r.cell_reverse = screen_img[c.row - 1][c.col - 1].reverse;
            end
         end
         default: ;
      endcase
      r.cursor_row = 5'(cur_line);
      r.cursor_col = 6'(cur_colm);
      return r;
   endfunction

   function automatic dir_row_t mk_row(input logic [2:0] m, input logic [7:0] r,
                                       input logic [7:0] c, input logic [7:0] re,
                                       input logic [7:0] ce, input logic [8:0] amt,
                                       input logic [7:0] ch, input logic [7:0] st,
                                       input bit typed, input logic [7:0] ec,
                                       input logic erv, input logic [4:0] er,
                                       input logic [5:0] ecc);
      dir_row_t d;
      d.cmd   = '{mode: m, row: r, col: c, row_end: re, col_end: ce,
                  scroll_amount: amt, char_code: ch, style_bits: st};
      d.typed = typed;
      d.res   = '{cursor_col: ecc, cursor_row: er, cell_reverse: erv, cell_char: ec};
      return d;
   endfunction

   function automatic cmd_type rand_cmd();
      cmd_type c;
      int      sel;
      c.mode          = 3'($urandom);
      c.row           = 8'($urandom);
      c.col           = 8'($urandom);
      c.row_end       = 8'($urandom);
      c.col_end       = 8'($urandom);
      c.scroll_amount = 9'($urandom);
      c.char_code     = 8'($urandom);
      c.style_bits    = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 32) begin
         c.mode = MODE_PUT_CHAR;
      end else if (sel < 55) begin
         c.mode = MODE_READ;
         if ($urandom_range(0, 9) != 0) begin
            c.row = 8'($urandom_range(1, ROWS));
            c.col = 8'($urandom_range(1, COLS));
         end
      end else if (sel < 67) begin
         c.mode = MODE_SET_CURSOR;
         if ($urandom_range(0, 6) != 0) begin
            c.row = 8'($urandom_range(1, ROWS));
            c.col = $urandom_range(0, 1) ? 8'($urandom_range(COLS - 3, COLS))
                                         : 8'($urandom_range(1, COLS));
         end
      end else if (sel < 73) begin
         c.mode = MODE_SET_STYLE;
      end else if (sel < 97) begin
         c.mode = (sel < 82) ? MODE_ERASE : MODE_SCROLL;
         if ($urandom_range(0, 9) != 0) begin
            c.row     = 8'($urandom_range(0, ROWS + 1));
            c.row_end = 8'(c.row + $urandom_range(0, 5));
            c.col     = 8'($urandom_range(0, COLS + 1));
            c.col_end = 8'(c.col + $urandom_range(0, 12));
            if ($urandom_range(0, 3) != 0)
               c.scroll_amount = 9'($urandom_range(0, 12)) - 9'd6;
         end
      end else begin
         c.mode = 3'($urandom_range(6, 7));
      end
      return c;
   endfunction

   task automatic send_request(input cmd_type c, input bit typed, input res_type typed_res);
      res_type r;
      int      gap;
      r = predict_screen(c);
      rsp_expect_q.push_back(typed ? typed_res : r);
      gap = 0;
      while (!quiet && $urandom_range(0, 99) < 21) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {7'd0, c.style_bits, c.char_code, c.scroll_amount,
                     c.col_end, c.row_end, c.col, c.row};
      req_tuser  <= c.mode;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic check_response(input logic [RSP_W-1:0] d);
      res_type e;
      results_seen++;
      if (rsp_expect_q.size() == 0) begin
         report_mismatch($sformatf("response %0d arrived with no request waiting",
                                   results_seen));
         return;
      end
      e = rsp_expect_q.pop_front();
      if (d[7:0] !== e.cell_char)
         report_mismatch($sformatf("response %0d cell_char %h, expected %h",
                                   results_seen, d[7:0], e.cell_char));
      if (d[8] !== e.cell_reverse)
         report_mismatch($sformatf("response %0d cell_reverse %b, expected %b",
                                   results_seen, d[8], e.cell_reverse));
      if (d[13:9] !== e.cursor_row)
         report_mismatch($sformatf("response %0d cursor_row %0d, expected %0d",
                                   results_seen, d[13:9], e.cursor_row));
      if (d[19:14] !== e.cursor_col)
         report_mismatch($sformatf("response %0d cursor_col %0d, expected %0d",
                                   results_seen, d[19:14], e.cursor_col));
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_response(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   initial begin
      foreach (screen_img[y, x]) screen_img[y][x] = '0;
      cur_line = 0;
      cur_colm = 0;
      rev_on   = 1'b0;

      dir_rows.push_back(mk_row(MODE_READ,       1,   1,   0,   0, 9'h000, 0, 0,
                                1, 8'h00, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_READ,       0,   0,   0,   0, 9'h000, 0, 0,
                                1, 8'h00, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_READ,      33,  65,   0,   0, 9'h000, 0, 0,
                                1, 8'h00, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SET_CURSOR, 0,   0,   0,   0, 9'h000, 0, 0,
                                1, 8'h00, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SET_CURSOR, 255, 255, 255, 255, 9'h1FF, 8'hFF, 8'hFF,
                                1, 8'h00, 0, 31, 63));
      dir_rows.push_back(mk_row(MODE_SET_STYLE,  0,   0,   0,   0, 9'h000, 0, 8'hFF,
                                1, 8'h00, 0, 31, 63));
      dir_rows.push_back(mk_row(MODE_PUT_CHAR,   0,   0,   0,   0, 9'h000, 8'hFF, 0,
                                1, 8'h00, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_READ,      32,  64,   0,   0, 9'h000, 0, 0,
                                1, 8'hFF, 1, 0, 0));
      dir_rows.push_back(mk_row(MODE_READ,       1,  64,   0,   0, 9'h000, 0, 0,
                                1, 8'h20, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SET_STYLE,  0,   0,   0,   0, 9'h000, 0, 8'hFE,
                                1, 8'h00, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SET_CURSOR, 3,   5,   0,   0, 9'h000, 0, 0,
                                1, 8'h00, 0, 2, 4));
      dir_rows.push_back(mk_row(MODE_PUT_CHAR,   0,   0,   0,   0, 9'h000, 8'h00, 0,
                                1, 8'h00, 0, 2, 5));
      dir_rows.push_back(mk_row(MODE_PUT_CHAR,   0,   0,   0,   0, 9'h000, 8'h41, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(3'd6, 255, 255, 255, 255, 9'h1FF, 8'hFF, 8'hFF,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(3'd7,   0,   0,   0,   0, 9'h000, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_READ,       3,   6,   0,   0, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_ERASE,      0,   0, 255, 255, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_ERASE,      5,   5,   4,  10, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_ERASE,      1,   1,   0,   0, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SET_CURSOR, 2,   1,   0,   0, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_PUT_CHAR,   0,   0,   0,   0, 9'h000, 8'h5A, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SCROLL,     1,   1,  32,  64, 9'h001, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_READ,       1,   1,   0,   0, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SCROLL,     0,   0, 255, 255, 9'h1FF, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SCROLL,     3,   2,   6,   9, 9'h0FF, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SCROLL,     1,   1,   4,   8, 9'h100, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_SCROLL,     1,   1,  32,  64, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(MODE_READ,       2,   1,   0,   0, 9'h000, 0, 0,
                                0, 0, 0, 0, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_request(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

      for (int i = 0; i < RAND_REQUESTS; i++) begin
         quiet = (i >= 250 && i < 400);
         if (i == HOLD_AT) hold_request = 1'b1;
         send_request(rand_cmd(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      quiet = 1'b0;

      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d requests (%0d directed), %0d responses checked, %0d row wraps",
               requests_sent, dir_rows.size(), results_seen, wrap_count);
      $display("with clipped erase and scroll areas, out-of-screen reads and a %0d-cycle stall",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== text_screen_cell_buffer_top.f =====
rtl/tscb_pkg.sv
rtl/tscb_cell_ram.sv
rtl/tscb_ctrl.sv
rtl/text_screen_cell_buffer_top.sv
tb/tb.sv
